@@ sv/assert_macros.svh @@
// Assertion macros shared by the convolution RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent property checked on every rising edge outside reset.
`define FLC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("convolution assertion failed");

// Condition that must never be true outside reset.
`define FLC_NEVER(label, clk, rst, expr) \
  `FLC_ASSERT(label, clk, rst, !(expr))

`else

`define FLC_ASSERT(label, clk, rst, prop)
`define FLC_NEVER(label, clk, rst, expr)

`endif

`endif

@@ sv/flc_pkg.sv @@
// Shared types and constants for the full linear convolution block.
`default_nettype none

package flc_pkg;

  localparam int MAX_TAPS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int DATA_W      = 16;
  localparam int CONV_W      = 38;
  localparam int OUT_TDATA_W = 40;
  localparam int ERR_W       = 2;

  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_KERNEL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic             kern_wr;      // append coefficient to kernel store
    logic             push_sample;  // push input sample into history, start a dot
    logic             push_zero;    // push a tail zero, start a dot
    logic             tail_load;    // arm tail counter from tap count
    logic             issue;        // issue one tap of the dot product
    logic             emit;         // load output register
    logic             emit_err;     // output value is zero (error result)
    logic [ERR_W-1:0] code;
    logic             last;
    logic             clear;        // drop kernel and history
  } flc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic tap_zero;
    logic tap_full;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
    logic tail_zero;
  } flc_stat_t;

endpackage

`default_nettype wire

@@ sv/full_linear_convolution.sv @@
// Full-mode 1-D convolution with streamed kernel load, one shared multiply-accumulate.
// A coefficient transfer yields no result (or one error result).
// Each output of a sample or of the tail makes one kernel and one history read per tap.
// Reset clears the tap count, the history fill count and the output valid; the stores
// themselves are not swept, entries past the fill or tap count are never used.
`default_nettype none

module full_linear_convolution #(
  parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [flc_pkg::DATA_W-1:0]   s_tdata,   // [15:0] data_value
  input  wire logic                         s_tuser,   // [0] req_type
  input  wire logic                         s_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [flc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [37:0] conv_value, [39:38] zero
  output logic [flc_pkg::ERR_W-1:0]         m_tuser,   // [1:0] error_code
  output logic                              m_tlast
);
  import flc_pkg::*;

  flc_cmd_t  cmd;
  flc_stat_t st;

  flc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .req_type     (s_tuser),
    .final_sample (s_tlast),
    .st           (st),
    .cmd          (cmd)
  );

  flc_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .data_in  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ sv/flc_ctrl.sv @@
// Sequencer for the convolution: input handshake, dot product steps, result issue.
`default_nettype none

`include "assert_macros.svh"

module flc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              req_type,
  input  wire logic              final_sample,
  input  wire flc_pkg::flc_stat_t st,
  output flc_pkg::flc_cmd_t      cmd
);
  import flc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic             err_pend, err_pend_next;
  logic [ERR_W-1:0] err_code, err_code_next;
  logic             err_last, err_last_next;
  logic             fin, fin_next;
  logic             accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next    = state;
    err_pend_next = err_pend;
    err_code_next = err_code;
    err_last_next = err_last;
    fin_next      = fin;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_COEF) begin
            if (st.tap_full) begin
              err_pend_next = 1'b1;
              err_code_next = ERR_FULL;
              err_last_next = 1'b0;
              state_next    = S_EMIT;
            end else begin
              cmd.kern_wr = 1'b1;
            end
          end else if (st.tap_zero) begin
            err_pend_next = 1'b1;
            err_code_next = ERR_NO_KERNEL;
            err_last_next = final_sample;
            state_next    = S_EMIT;
          end else begin
            cmd.push_sample = 1'b1;
            cmd.tail_load   = final_sample;
            fin_next        = final_sample;
            err_pend_next   = 1'b0;
            state_next      = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (st.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!st.pipe_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_err = err_pend;
          cmd.code     = err_pend ? err_code : ERR_OK;
          cmd.last     = err_pend ? err_last : (fin && st.tail_zero);
          if (err_pend) begin
            err_pend_next = 1'b0;
            state_next    = S_IDLE;
          end else if (!st.tail_zero) begin
            // flush one more tail output
            cmd.push_zero = 1'b1;
            state_next    = S_MAC;
          end else begin
            cmd.clear  = fin;
            fin_next   = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_pend <= 1'b0;
      fin      <= 1'b0;
    end else begin
      state    <= state_next;
      err_pend <= err_pend_next;
      fin      <= fin_next;
    end
    err_code <= err_code_next;
    err_last <= err_last_next;
  end

  `FLC_ASSERT(a_mac_has_kernel, clk, rst, (state == S_MAC) |-> !st.tap_zero)
  `FLC_ASSERT(a_emit_leaves, clk, rst, cmd.emit |=> (state != S_EMIT))
  `FLC_NEVER(a_push_outside_idle_emit, clk, rst,
             (cmd.push_sample || cmd.push_zero) && (state == S_MAC || state == S_DRAIN))

endmodule

`default_nettype wire

@@ sv/flc_datapath.sv @@
// Kernel and history memories, multiply-accumulate pipeline and output register.
`default_nettype none

`include "assert_macros.svh"

module flc_datapath #(
  parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire flc_pkg::flc_cmd_t               cmd,
  output flc_pkg::flc_stat_t                   st,
  input  wire logic [flc_pkg::DATA_W-1:0]      data_in,
  input  wire logic                            m_tready,
  output logic                                 m_tvalid,
  output logic [flc_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,
  output logic [flc_pkg::ERR_W-1:0]            m_tuser
);
  import flc_pkg::*;

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW     = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] kmem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hmem [MAX_TAPS];

  logic [CW-1:0] tap_count;
  logic [CW-1:0] fill;
  logic [CW-1:0] tail;
  logic [AW-1:0] wptr, wptr_inc;
  logic [AW-1:0] rptr, rptr_dec;
  logic [AW-1:0] cnt;

  logic signed [SAMPLE_BITS-1:0] din, push_val;
  logic signed [SAMPLE_BITS-1:0] kd, hd;
  logic                          v1, z1, v2;
  logic signed [PROD_W-1:0]      prod;
  logic [CONV_W-1:0]             acc;
  logic [CONV_W-1:0]             conv;
  logic                          push;

  assign din      = SAMPLE_BITS'($signed(data_in));
  assign push     = cmd.push_sample || cmd.push_zero;
  assign push_val = cmd.push_zero ? '0 : din;
  assign wptr_inc = (wptr == AW'(MAX_TAPS - 1)) ? '0 : wptr + AW'(1);
  assign rptr_dec = (rptr == '0) ? AW'(MAX_TAPS - 1) : rptr - AW'(1);

  // Memories with registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.kern_wr) begin
      kmem[tap_count[AW-1:0]] <= din;
    end
    kd <= kmem[cnt];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hmem[wptr_inc] <= push_val;
    end
    hd <= hmem[rptr];
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= '0;
      fill      <= '0;
      tail      <= '0;
      wptr      <= '0;
      rptr      <= '0;
      cnt       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.clear) begin
        tap_count <= '0;
        fill      <= '0;
      end else begin
        if (cmd.kern_wr) begin
          tap_count <= tap_count + CW'(1);
        end
        if (push && (fill != CW'(MAX_TAPS))) begin
          fill <= fill + CW'(1);
        end
      end
      if (cmd.push_sample) begin
        tail <= cmd.tail_load ? (tap_count - CW'(1)) : '0;
      end else if (cmd.push_zero) begin
        tail <= tail - CW'(1);
      end
      if (push) begin
        wptr <= wptr_inc;
        rptr <= wptr_inc;
        cnt  <= '0;
      end else if (cmd.issue) begin
        rptr <= rptr_dec;
        cnt  <= cnt + AW'(1);
      end
    end
  end

  // Multiply-accumulate pipeline; history entries beyond the fill read as zero.
  always_ff @(posedge clk) begin
    z1 <= (CW'(cnt) < fill);
    if (z1) begin
      prod <= kd * hd;
    end else begin
      prod <= '0;
    end
    if (push) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + CONV_W'(prod);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.emit) begin
      conv    <= cmd.emit_err ? '0 : acc;
      m_tlast <= cmd.last;
      m_tuser <= cmd.code;
    end
  end

  assign m_tdata = OUT_TDATA_W'(conv);

  assign st.tap_zero   = (tap_count == '0);
  assign st.tap_full   = (tap_count == CW'(MAX_TAPS));
  assign st.last_issue = (CW'(cnt) == (tap_count - CW'(1)));
  assign st.pipe_busy  = v1 || v2;
  assign st.out_free   = !m_tvalid || m_tready;
  assign st.tail_zero  = (tail == '0);

  `FLC_ASSERT(a_emit_slot_free, clk, rst, cmd.emit |-> (!m_tvalid || m_tready))
  `FLC_ASSERT(a_acc_cleared, clk, rst, push |=> (acc == '0))
  `FLC_NEVER(a_kern_wr_busy, clk, rst, cmd.kern_wr && (v1 || v2))
  `FLC_ASSERT(a_tap_bound, clk, rst, cmd.kern_wr |-> (tap_count != CW'(MAX_TAPS)))

endmodule

`default_nettype wire
